// ===== sv/vstc_pkg.sv =====
// Shared types and constants for the virtual system time clock bank.
package vstc_pkg;

    // Action codes as they arrive on the input channel
    localparam logic [2:0] ACT_ALLOC  = 3'd0;
    localparam logic [2:0] ACT_FREE   = 3'd1;
    localparam logic [2:0] ACT_START  = 3'd2;
    localparam logic [2:0] ACT_STOP   = 3'd3;
    localparam logic [2:0] ACT_GET    = 3'd4;
    localparam logic [2:0] ACT_SET    = 3'd5;
    localparam logic [2:0] ACT_ADJUST = 3'd6;

    localparam int ID_W    = 5;
    localparam int COUNT_W = 58;
    localparam int TIME_W  = 64;

    // 13 MHz -> 90 kHz: floor(count * 27 / (13 * 300))
    localparam int CNT_MUL     = 27;
    localparam int CNT_DIV     = 13 * 300;
    localparam int DIV_REM_W   = $clog2(CNT_DIV);
    localparam int DIV_BITS    = 16;
    localparam int DIV_STEPS   = TIME_W / DIV_BITS;
    localparam int DIV_CYC     = 2 * DIV_STEPS;
    localparam int DIV_CYC_W   = $clog2(DIV_CYC);
    localparam int DIV_X_W     = DIV_REM_W + DIV_BITS;
    // ceil(2^DIV_SHIFT / CNT_DIV); quotient is exact for partial dividends below 2^DIV_X_W
    localparam int DIV_SHIFT   = 40;
    localparam int DIV_RECIP   = 281926059;
    localparam int DIV_RECIP_W = 29;
    localparam int DIV_PROD_W  = DIV_X_W + DIV_RECIP_W;

    // Operation after front-end classification
    typedef enum logic [2:0] {
        OP_ALLOC,
        OP_FREE,
        OP_START,
        OP_STOP,
        OP_GET,
        OP_SET,
        OP_ADJUST,
        OP_FAIL
    } t_op;

    typedef struct packed {
        t_op                       op;
        logic [ID_W-1:0]           slot;
        logic signed [TIME_W-1:0]  value;
        logic [COUNT_W-1:0]        now_count;
        logic                      need_ticks;
    } t_cmd;

endpackage

// ===== sv/virtual_system_time_clock_bank.sv =====
// Top level of the virtual system time clock bank: front end, queue, back end.
//
//  Channel | Handshake                   | Payload
//  --------+-----------------------------+--------------------------------------------
//  input   | i_in_valid / o_in_stall     | i_action, i_instance_req, i_value, i_now_count
//  output  | o_out_valid / i_out_stall   | o_status, o_granted_id, o_time_value
//
// Start, stop, get and set: the command passes the queue, is taken into the back end
// and waits there for the count conversion (four 16-bit quotient digits, each a multiply
// step and then a digit step); the result is registered once the output is not stalled.
// Alloc, free, adjust and failed requests skip the conversion. The back end takes one
// command at a time and returns to idle only once its result register is written.
// A two-entry queue takes transfers while the back end is busy or stalled; the input
// stalls once it is full.
// Reset is synchronous and clears all clocks and allocations.
module virtual_system_time_clock_bank #(
    parameter int NUM_INSTANCES = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [2:0]                         i_action,
    input  logic [vstc_pkg::ID_W-1:0]          i_instance_req,
    input  logic signed [vstc_pkg::TIME_W-1:0] i_value,
    input  logic [vstc_pkg::COUNT_W-1:0]       i_now_count,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_status,
    output logic [vstc_pkg::ID_W-1:0]          o_granted_id,
    output logic signed [vstc_pkg::TIME_W-1:0] o_time_value
);
    import vstc_pkg::*;

    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_nempty;
    t_cmd w_front_cmd;
    t_cmd w_queue_cmd;

    vstc_front #(
        .NUM_INSTANCES (NUM_INSTANCES)
    ) u_front (
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_instance_req (i_instance_req),
        .i_value        (i_value),
        .i_now_count    (i_now_count),
        .i_q_full       (w_full),
        .o_push         (w_push),
        .o_cmd          (w_front_cmd)
    );

    vstc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_front_cmd),
        .o_full   (w_full),
        .o_nempty (w_nempty),
        .i_pop    (w_pop),
        .o_cmd    (w_queue_cmd)
    );

    vstc_back #(
        .NUM_INSTANCES (NUM_INSTANCES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nempty   (w_nempty),
        .i_cmd        (w_queue_cmd),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_granted_id (o_granted_id),
        .o_time_value (o_time_value)
    );

    // granted slot always lies inside the bank
    a_granted_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_granted_id) < NUM_INSTANCES))
        else $error("granted id outside bank");

    // a failed request carries no slot and no time
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (o_granted_id == '0 && o_time_value == '0))
        else $error("failed result with nonzero payload");

    // the back end only pulls from a non-empty queue
    a_pop_nempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_nempty)
        else $error("pop from empty queue");

    // a command that entered an empty queue is pulled or still waiting next cycle
    a_queue_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_nempty) |=> w_nempty)
        else $error("queue lost a transfer");

endmodule

// ===== sv/vstc_front.sv =====
// Front end: decodes the action and range-checks the instance id.
module vstc_front #(
    parameter int NUM_INSTANCES = 4
) (
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [2:0]                        i_action,
    input  logic [vstc_pkg::ID_W-1:0]         i_instance_req,
    input  logic signed [vstc_pkg::TIME_W-1:0] i_value,
    input  logic [vstc_pkg::COUNT_W-1:0]      i_now_count,
    input  logic                              i_q_full,
    output logic                              o_push,
    output vstc_pkg::t_cmd                    o_cmd
);
    import vstc_pkg::*;

    logic w_id_ok;
    t_op  w_op;

    assign w_id_ok = (32'(i_instance_req) < NUM_INSTANCES);

    always_comb begin
        w_op = OP_FAIL;
        case (i_action)
            ACT_ALLOC:  w_op = OP_ALLOC;
            ACT_FREE:   w_op = w_id_ok ? OP_FREE   : OP_FAIL;
            ACT_START:  w_op = w_id_ok ? OP_START  : OP_FAIL;
            ACT_STOP:   w_op = w_id_ok ? OP_STOP   : OP_FAIL;
            ACT_GET:    w_op = w_id_ok ? OP_GET    : OP_FAIL;
            ACT_SET:    w_op = w_id_ok ? OP_SET    : OP_FAIL;
            ACT_ADJUST: w_op = w_id_ok ? OP_ADJUST : OP_FAIL;
            default:    w_op = OP_FAIL;
        endcase
    end

    assign o_in_stall       = i_q_full;
    assign o_push           = i_in_valid && !i_q_full;
    assign o_cmd.op         = w_op;
    assign o_cmd.slot       = i_instance_req;
    assign o_cmd.value      = i_value;
    assign o_cmd.now_count  = i_now_count;
    // only these read the converted count
    assign o_cmd.need_ticks = (w_op == OP_START) || (w_op == OP_STOP) ||
                              (w_op == OP_GET) || (w_op == OP_SET);

endmodule

// ===== sv/vstc_queue.sv =====
// Two-entry command queue between front end and back end.
module vstc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  vstc_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_nempty,
    input  logic           i_pop,
    output vstc_pkg::t_cmd o_cmd
);
    import vstc_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    assign o_full   = (r_cnt == 2'd2);
    assign o_nempty = (r_cnt != 2'd0);
    assign o_cmd    = r_mem[r_rd];

endmodule

// ===== sv/vstc_div.sv =====
// 13 MHz count to 90 kHz tick converter: reciprocal long division, 16 quotient bits per digit.
module vstc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [vstc_pkg::COUNT_W-1:0]  i_count,
    output logic                          o_done,
    output logic [vstc_pkg::TIME_W-1:0]   o_ticks
);
    import vstc_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CYC_W-1:0]  r_step;
    logic [DIV_REM_W-1:0]  r_rem;
    logic [TIME_W-1:0]     r_dq;   // dividend digits shift out the top, quotient in the bottom
    logic [DIV_PROD_W-1:0] r_prod;
    logic [TIME_W-1:0]     w_count;
    logic [DIV_X_W-1:0]    w_x;
    logic [DIV_BITS-1:0]   w_q;
    logic [DIV_X_W-1:0]    w_qd;
    logic [DIV_X_W-1:0]    w_rem;

    assign w_count = TIME_W'(i_count);
    // partial dividend: running remainder and the next dividend digit
    assign w_x     = {r_rem, r_dq[TIME_W-1 -: DIV_BITS]};
    // even phase multiplies by the reciprocal, odd phase takes the digit and remainder
    assign w_q     = r_prod[DIV_SHIFT +: DIV_BITS];
    assign w_qd    = DIV_X_W'(w_q) * DIV_X_W'(CNT_DIV);
    assign w_rem   = w_x - w_qd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_step == DIV_CYC_W'(DIV_CYC - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + DIV_CYC_W'(1);
                if (r_step == DIV_CYC_W'(DIV_CYC - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dq  <= w_count * TIME_W'(CNT_MUL);
            r_rem <= '0;
        end else if (r_busy) begin
            if (!r_step[0]) begin
                r_prod <= DIV_PROD_W'(w_x) * DIV_PROD_W'(DIV_RECIP);
            end else begin
                r_dq  <= {r_dq[TIME_W-DIV_BITS-1:0], w_q};
                r_rem <= w_rem[DIV_REM_W-1:0];
            end
        end
    end

    assign o_done  = r_done;
    assign o_ticks = r_dq;

endmodule

// ===== sv/vstc_back.sv =====
// Back end: clock state, command execution and the result register.
module vstc_back #(
    parameter int NUM_INSTANCES = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_nempty,
    input  vstc_pkg::t_cmd                     i_cmd,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_status,
    output logic [vstc_pkg::ID_W-1:0]          o_granted_id,
    output logic signed [vstc_pkg::TIME_W-1:0] o_time_value
);
    import vstc_pkg::*;

    localparam int SLOT_W = (NUM_INSTANCES > 1) ? $clog2(NUM_INSTANCES) : 1;
    localparam int USED_W = $clog2(NUM_INSTANCES + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EXEC
    } t_state;

    t_state             r_state;
    t_cmd               r_cmd;
    logic [TIME_W-1:0]  r_offset [NUM_INSTANCES];
    logic [NUM_INSTANCES-1:0] r_in_use;
    logic [NUM_INSTANCES-1:0] r_running;
    logic [USED_W-1:0]  r_slots_used;
    logic               r_out_valid;
    logic               r_status;
    logic [ID_W-1:0]    r_granted_id;
    logic [TIME_W-1:0]  r_time_value;

    logic               w_div_start;
    logic               w_div_done;
    logic [TIME_W-1:0]  w_ticks;
    logic               w_fire;

    logic [SLOT_W-1:0]  w_free_idx;
    logic               w_free_found;
    logic [SLOT_W-1:0]  w_slot;
    logic [TIME_W-1:0]  w_cur;
    logic               w_run;
    logic [TIME_W-1:0]  w_now_sel;

    logic               n_status;
    logic [ID_W-1:0]    n_granted_id;
    logic [TIME_W-1:0]  n_time_value;
    logic               n_wr;
    logic [SLOT_W-1:0]  n_wr_slot;
    logic [TIME_W-1:0]  n_off;
    logic               n_run;
    logic               n_use;
    logic [USED_W-1:0]  n_slots_used;

    vstc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_count (i_cmd.now_count),
        .o_done  (w_div_done),
        .o_ticks (w_ticks)
    );

    assign o_pop       = (r_state == ST_IDLE) && i_q_nempty;
    assign w_div_start = o_pop && i_cmd.need_ticks;
    assign w_fire      = (r_state == ST_EXEC) && (!r_out_valid || !i_out_stall);

    // lowest free slot
    always_comb begin
        w_free_idx   = '0;
        w_free_found = 1'b0;
        for (int k = NUM_INSTANCES - 1; k >= 0; k--) begin
            if (!r_in_use[k]) begin
                w_free_idx   = SLOT_W'(k);
                w_free_found = 1'b1;
            end
        end
    end

    assign w_slot    = r_cmd.slot[SLOT_W-1:0];
    assign w_cur     = r_offset[w_slot];
    assign w_run     = r_running[w_slot];
    assign w_now_sel = w_run ? w_ticks : '0;

    always_comb begin
        n_status     = 1'b1;
        n_granted_id = '0;
        n_time_value = '0;
        n_wr         = 1'b0;
        n_wr_slot    = w_slot;
        n_off        = w_cur;
        n_run        = w_run;
        n_use        = 1'b1;
        n_slots_used = r_slots_used;
        case (r_cmd.op)
            OP_ALLOC: begin
                if (r_slots_used < USED_W'(NUM_INSTANCES) && w_free_found) begin
                    n_status     = 1'b0;
                    n_granted_id = ID_W'(w_free_idx);
                    n_wr         = 1'b1;
                    n_wr_slot    = w_free_idx;
                    n_off        = '0;
                    n_run        = 1'b0;
                    n_slots_used = r_slots_used + USED_W'(1);
                end
            end
            OP_FAIL: begin
                n_status = 1'b1;
            end
            default: begin
                // id range already checked up front; slot must be allocated
                if (r_in_use[w_slot]) begin
                    n_status = 1'b0;
                    n_wr     = 1'b1;
                    case (r_cmd.op)
                        OP_FREE: begin
                            n_off = '0;
                            n_run = 1'b0;
                            n_use = 1'b0;
                            if (r_slots_used != '0) begin
                                n_slots_used = r_slots_used - USED_W'(1);
                            end
                        end
                        OP_START: begin
                            if (!w_run) begin
                                n_off = w_cur - w_ticks;
                                n_run = 1'b1;
                            end
                        end
                        OP_STOP: begin
                            if (w_run) begin
                                n_off = w_cur + w_ticks;
                                n_run = 1'b0;
                            end
                        end
                        OP_GET:    n_time_value = w_cur + w_now_sel;
                        OP_SET:    n_off = r_cmd.value - w_now_sel;
                        OP_ADJUST: n_off = w_cur + r_cmd.value;
                        default:   n_wr = 1'b0;
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_in_use     <= '0;
            r_running    <= '0;
            r_slots_used <= '0;
            r_out_valid  <= 1'b0;
            for (int k = 0; k < NUM_INSTANCES; k++) begin
                r_offset[k] <= '0;
            end
        end else begin
            r_out_valid <= w_fire || (r_out_valid && i_out_stall);
            case (r_state)
                ST_IDLE: begin
                    if (i_q_nempty) begin
                        r_cmd   <= i_cmd;
                        r_state <= i_cmd.need_ticks ? ST_CONV : ST_EXEC;
                    end
                end
                ST_CONV: begin
                    if (w_div_done) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (w_fire) begin
                        r_status     <= n_status;
                        r_granted_id <= n_granted_id;
                        r_time_value <= n_time_value;
                        r_slots_used <= n_slots_used;
                        if (n_wr) begin
                            r_offset[n_wr_slot]  <= n_off;
                            r_running[n_wr_slot] <= n_run;
                            r_in_use[n_wr_slot]  <= n_use;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_granted_id = r_granted_id;
    assign o_time_value = r_time_value;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the virtual system time clock bank.
module tb;
    import vstc_pkg::*;

    localparam int          NUM_SLOTS   = 4;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          SETTLE_CYC  = 24;
    localparam logic [63:0] TICK_MUL    = 64'd27;
    localparam logic [63:0] TICK_DIV_A  = 64'd13;
    localparam logic [63:0] TICK_DIV_B  = 64'd300;
    localparam logic [57:0] COUNT_MAX   = {COUNT_W{1'b1}};
    localparam logic [63:0] VAL_MIN     = 64'h8000_0000_0000_0000;
    localparam logic [63:0] VAL_MAX     = 64'h7fff_ffff_ffff_ffff;
    localparam logic [2:0]  ACT_BAD     = 3'd7;

    typedef struct packed {
        logic              status;
        logic [ID_W-1:0]   granted;
        logic [TIME_W-1:0] tval;
    } t_clock_reply;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic [2:0]                i_action = '0;
    logic [ID_W-1:0]           i_instance_req = '0;
    logic signed [TIME_W-1:0]  i_value = '0;
    logic [COUNT_W-1:0]        i_now_count = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic                      o_status;
    logic [ID_W-1:0]           o_granted_id;
    logic signed [TIME_W-1:0]  o_time_value;

    // predictor copy of the bank
    logic [TIME_W-1:0] clk_offset [NUM_SLOTS];
    logic              clk_in_use [NUM_SLOTS];
    logic              clk_running [NUM_SLOTS];
    int                clocks_allocated;

    t_clock_reply expected_replies[$];
    int           err_count = 0;
    int           cycle_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           hold_left = 0;

    virtual_system_time_clock_bank #(.NUM_INSTANCES(NUM_SLOTS)) dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: long hold-off when armed, random stalls otherwise
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    function automatic logic [63:0] count_to_ticks(input logic [COUNT_W-1:0] cnt);
        logic [63:0] scaled;
        scaled = 64'(cnt) * TICK_MUL;
        return (scaled / TICK_DIV_A) / TICK_DIV_B;
    endfunction

    function automatic t_clock_reply predict_clock_bank(input logic [2:0] act,
                                                        input logic [ID_W-1:0] id,
                                                        input logic [TIME_W-1:0] val,
                                                        input logic [COUNT_W-1:0] cnt);
        t_clock_reply r;
        logic [63:0]  ticks;
        logic         found;
        int           s;
        r = '0;
        r.status = 1'b1;
        ticks = count_to_ticks(cnt);
        s = int'(id);
        found = 1'b0;
        if (act == ACT_ALLOC) begin
            if (clocks_allocated < NUM_SLOTS) begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!found && !clk_in_use[i]) begin
                        found = 1'b1;
                        clk_offset[i] = '0;
                        clk_in_use[i] = 1'b1;
                        clk_running[i] = 1'b0;
                        clocks_allocated++;
                        r.granted = ID_W'(i);
                        r.status = 1'b0;
                    end
                end
            end
        end else if (act != ACT_BAD && s < NUM_SLOTS && clk_in_use[s]) begin
            r.status = 1'b0;
            case (act)
                ACT_FREE: begin
                    clk_offset[s] = '0;
                    clk_in_use[s] = 1'b0;
                    clk_running[s] = 1'b0;
                    if (clocks_allocated > 0) clocks_allocated--;
                end
                ACT_START: begin
                    if (!clk_running[s]) begin
                        clk_offset[s] = clk_offset[s] - ticks;
                        clk_running[s] = 1'b1;
                    end
                end
                ACT_STOP: begin
                    if (clk_running[s]) begin
                        clk_offset[s] = clk_offset[s] + ticks;
                        clk_running[s] = 1'b0;
                    end
                end
                ACT_GET: r.tval = clk_offset[s] + (clk_running[s] ? ticks : 64'd0);
                ACT_SET: clk_offset[s] = val - (clk_running[s] ? ticks : 64'd0);
                default: clk_offset[s] = clk_offset[s] + val;
            endcase
        end
        return r;
    endfunction

    // one request: optional idle gap, offer, wait for the transfer, predict
    task automatic issue_request(input logic [2:0] act, input logic [ID_W-1:0] id,
                                 input logic [TIME_W-1:0] val,
                                 input logic [COUNT_W-1:0] cnt);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_action       <= act;
        i_instance_req <= id;
        i_value        <= val;
        i_now_count    <= cnt;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_replies.push_back(predict_clock_bank(act, id, val, cnt));
    endtask

    task automatic wait_for_replies();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : check_replies
        t_clock_reply exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_replies.size() == 0) begin
                $error("result with nothing expected: status %0d id %0d time %0h",
                       o_status, o_granted_id, o_time_value);
                err_count++;
            end else begin
                exp_r = expected_replies.pop_front();
                if (o_status !== exp_r.status) begin
                    $error("status: expected %0d got %0d", exp_r.status, o_status);
                    err_count++;
                end
                if (o_granted_id !== exp_r.granted) begin
                    $error("granted_id: expected %0d got %0d", exp_r.granted, o_granted_id);
                    err_count++;
                end
                if (o_time_value !== exp_r.tval) begin
                    $error("time_value: expected %0h got %0h", exp_r.tval, o_time_value);
                    err_count++;
                end
            end
        end
    end

    task automatic test_directed();
        issue_request(ACT_GET, 5'd0, '0, '0);              // nothing allocated yet
        issue_request(ACT_FREE, 5'd1, '0, '0);
        repeat (4) issue_request(ACT_ALLOC, 5'd31, VAL_MAX, COUNT_MAX);
        issue_request(ACT_ALLOC, 5'd0, '0, '0);            // bank full
        issue_request(ACT_GET, 5'd31, '0, COUNT_MAX);      // ids past the bank size
        issue_request(ACT_SET, 5'd4, VAL_MAX, '0);
        issue_request(ACT_BAD, 5'd0, '1, COUNT_MAX);       // unknown action
        issue_request(ACT_START, 5'd0, '0, COUNT_MAX);
        issue_request(ACT_GET, 5'd0, '0, COUNT_MAX);
        issue_request(ACT_STOP, 5'd0, '0, '0);             // stopped clock reads negative
        issue_request(ACT_GET, 5'd0, '0, COUNT_MAX);
        issue_request(ACT_SET, 5'd1, VAL_MIN, COUNT_MAX);
        issue_request(ACT_ADJUST, 5'd1, VAL_MAX, '0);
        issue_request(ACT_START, 5'd1, '0, 58'd3900);
        issue_request(ACT_START, 5'd1, '0, COUNT_MAX);     // already running
        issue_request(ACT_STOP, 5'd2, '0, COUNT_MAX);      // already stopped
        issue_request(ACT_SET, 5'd1, VAL_MAX, COUNT_MAX);  // set while running
        issue_request(ACT_GET, 5'd1, '0, 58'd3899);
        issue_request(ACT_FREE, 5'd2, '0, '0);
        issue_request(ACT_ALLOC, 5'd0, '0, '0);            // takes slot 2 back
        issue_request(ACT_GET, 5'd2, '0, COUNT_MAX);
        wait_for_replies();
    endtask

    task automatic random_request();
        logic [2:0]         act;
        logic [ID_W-1:0]    id;
        logic [TIME_W-1:0]  val;
        logic [COUNT_W-1:0] cnt;
        int                 pick;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 10) begin
            act = 3'($urandom_range(0, 7));
            id  = ID_W'($urandom_range(0, 31));
        end else begin
            id = ID_W'($urandom_range(0, NUM_SLOTS - 1));
            if (pick < 12)      act = ACT_ALLOC;
            else if (pick < 20) act = ACT_FREE;
            else if (pick < 35) act = ACT_START;
            else if (pick < 50) act = ACT_STOP;
            else if (pick < 75) act = ACT_GET;
            else if (pick < 85) act = ACT_SET;
            else                act = ACT_ADJUST;
        end
        val = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 5)       cnt = '0;
        else if (pick < 10) cnt = COUNT_MAX;
        else if (pick < 30) cnt = COUNT_W'($urandom);
        else                cnt = COUNT_W'({$urandom, $urandom});
        issue_request(act, id, val, cnt);
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n) random_request();
        wait_for_replies();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // receiver holds off long enough for the queue to fill and stall the input
    task automatic test_output_holdoff();
        hold_left = 80;
        repeat (12) random_request();
        wait_for_replies();
    endtask

    initial begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            clk_offset[i]  = '0;
            clk_in_use[i]  = 1'b0;
            clk_running[i] = 1'b0;
        end
        clocks_allocated = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_phase(0, 0, 325);
        test_output_holdoff();
        test_random_phase(48, 0, 325);
        test_random_phase(0, 48, 325);
        test_random_phase(9, 9, 325);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
